@@ rtl/sparx64_128_block_encrypt_defines.svh @@
// Assertion macros shared by the SPARX-64/128 encryption RTL.
// No dependencies; the including module must provide clk and rst.
`ifndef SPARX64_128_BLOCK_ENCRYPT_DEFINES_SVH
`define SPARX64_128_BLOCK_ENCRYPT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sparx_pkg.sv @@
// Types, constants and round functions for the SPARX-64/128 encryption pipeline.
// No dependencies.
package sparx_pkg;

  localparam int ROUNDS_DEFAULT = 8;
  localparam int KEYS_PER_ROUND = 6;
  // Highest table position that a load transaction can address.
  localparam int KEY_INDEX_MAX  = 63;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ENCRYPT = 1'b1;

  // One transaction as it travels down the pipeline.
  typedef struct packed {
    logic        vld;
    logic        func;
    logic [5:0]  idx;
    logic [31:0] word;
    logic [63:0] data;
  } sparx_item_t;

  // Speck-32 style ARX box on one 32-bit branch; lo is the low half.
  function automatic logic [31:0] arx_box(input logic [31:0] x);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = {x[6:0], x[15:7]};
    lo = lo + x[31:16];
    hi = {x[29:16], x[31:30]};
    hi = hi ^ lo;
    return {hi, lo};
  endfunction

  // Linear layer: x ^ rotl8(x) ^ rotr8(x).
  function automatic logic [31:0] lin_mix(input logic [31:0] x);
    return x ^ {x[23:0], x[31:24]} ^ {x[7:0], x[31:8]};
  endfunction

endpackage

@@ rtl/sparx_round.sv @@
// One SPARX round as a pipeline stage, holding its own six round-key words.
// Depends on sparx_pkg.
module sparx_round import sparx_pkg::*; #(
  parameter int KEY_BASE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  sparx_item_t item_in,
  output sparx_item_t item_out
);

  logic [31:0] keys [KEYS_PER_ROUND];
  logic [31:0] rkey [KEYS_PER_ROUND];
  logic [KEYS_PER_ROUND-1:0] hit;
  logic [31:0] left_a, left_b, left_c;
  logic [31:0] right_a, right_b, right_c;
  logic [63:0] data_next;
  logic        vld;
  logic        func;
  logic [5:0]  idx;
  logic [31:0] word;
  logic [63:0] data;

  // A load transaction writes a key word of this round as it passes.
  always_comb begin
    for (int j = 0; j < KEYS_PER_ROUND; j++) begin
      hit[j] = item_in.vld && (item_in.func == FUNC_LOAD) &&
               ({1'b0, item_in.idx} == 7'(KEY_BASE + j));
    end
  end

  // Key positions beyond the loadable range read as zero.
  always_comb begin
    for (int j = 0; j < KEYS_PER_ROUND; j++) begin
      rkey[j] = (KEY_BASE + j > KEY_INDEX_MAX) ? 32'h0 : keys[j];
    end
  end

  // Three keyed ARX boxes on each branch, then the linear layer and swap.
  always_comb begin
    left_a    = arx_box(item_in.data[31:0] ^ rkey[0]);
    left_b    = arx_box(left_a ^ rkey[1]);
    left_c    = arx_box(left_b ^ rkey[2]);
    right_a   = arx_box(item_in.data[63:32] ^ rkey[3]);
    right_b   = arx_box(right_a ^ rkey[4]);
    right_c   = arx_box(right_b ^ rkey[5]);
    data_next = {left_c, right_c ^ lin_mix(left_c)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= item_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func <= item_in.func;
      idx  <= item_in.idx;
      word <= item_in.word;
      data <= data_next;
      for (int j = 0; j < KEYS_PER_ROUND; j++) begin
        if (hit[j]) begin
          keys[j] <= item_in.word;
        end
      end
    end
  end

  assign item_out = '{vld: vld, func: func, idx: idx, word: word, data: data};

endmodule

@@ rtl/sparx64_128_block_encrypt.sv @@
// SPARX-64/128 encryption pipeline: one register stage per round, then whitening.
// An accepted encrypt transaction passes the round stages, then the output register, to its ciphertext.
// Throughput: one transaction per cycle while the output is not stalled; load transactions
// flow through the same stages and write each stage's own key words in order.
// Reset clears all valid bits; the key words are undefined until loaded.
// Depends on sparx_pkg, sparx_round and sparx64_128_block_encrypt_defines.svh.
`include "sparx64_128_block_encrypt_defines.svh"
module sparx64_128_block_encrypt import sparx_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [5:0]  key_index,
  input  logic [31:0] key_word,
  input  logic [63:0] plaintext,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] ciphertext
);

  localparam int WHITE_BASE = KEYS_PER_ROUND * ROUNDS;

  sparx_item_t stage [ROUNDS+1];
  logic        en;
  logic        last_enc;
  logic [31:0] white_keys [2];
  logic [31:0] white_rd [2];

  // The whole pipeline holds while a result waits on a stalled output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign stage[0] = '{vld: in_valid, func: func, idx: key_index,
                      word: key_word, data: plaintext};

  // One stage per round.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    sparx_round #(.KEY_BASE(KEYS_PER_ROUND * r)) u_round (
      .clk(clk), .rst(rst), .en(en),
      .item_in(stage[r]), .item_out(stage[r+1])
    );
  end

  assign last_enc = stage[ROUNDS].vld && (stage[ROUNDS].func == FUNC_ENCRYPT);

  // Output register: only encrypt transactions give a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last_enc;
    end
  end

  // Whitening key positions beyond the loadable range read as zero.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      white_rd[j] = (WHITE_BASE + j > KEY_INDEX_MAX) ? 32'h0 : white_keys[j];
    end
  end

  // Post-whitening, and the two whitening key words loaded in passing.
  always_ff @(posedge clk) begin
    if (en) begin
      ciphertext <= {stage[ROUNDS].data[63:32] ^ white_rd[1],
                     stage[ROUNDS].data[31:0] ^ white_rd[0]};
      for (int j = 0; j < 2; j++) begin
        if (stage[ROUNDS].vld && (stage[ROUNDS].func == FUNC_LOAD) &&
            ({1'b0, stage[ROUNDS].idx} == 7'(WHITE_BASE + j))) begin
          white_keys[j] <= stage[ROUNDS].word;
        end
      end
    end
  end

  `SPX_ASSERT_NEXT(a_hold_last, !en, $stable(stage[ROUNDS]), "last stage moved while stalled")
  `SPX_ASSERT_NEXT(a_result_src, en && !last_enc, !out_valid, "result without encrypt")
  `SPX_ASSERT_SAME(a_stall_src, in_stall, out_valid, "input stalled with no pending result")

endmodule
